[rtl/sapd_pkg.sv]
// Shared types and constants for the six-axis serial packet decoder.
`default_nettype none

package sapd_pkg;

    localparam int unsigned STORE_DEPTH = 12;
    localparam int unsigned STORE_IDX_W = 4;
    localparam int unsigned BYTE_W      = 7;
    localparam int unsigned AXIS_W      = 10;
    localparam int unsigned KEY_LEN     = 9;

    // packet type bytes
    localparam logic [BYTE_W-1:0] TYPE_MOTION = 7'h44;  // 'D'
    localparam logic [BYTE_W-1:0] TYPE_KEYS   = 7'h4b;  // 'K'
    localparam logic [BYTE_W-1:0] TYPE_ERROR  = 7'h45;  // 'E'

    localparam logic [3:0] LEN_MOTION = 4'd12;
    localparam logic [3:0] LEN_KEYS   = 4'd5;
    localparam logic [3:0] LEN_ERROR  = 4'd4;

    localparam logic [1:0] KIND_MOTION = 2'd0;
    localparam logic [1:0] KIND_KEYS   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // descramble key "SpaceWare", applied to bytes 2..10 of a motion packet
    localparam logic [BYTE_W-1:0] DESCRAMBLE_KEY [KEY_LEN] = '{
        7'h53, 7'h70, 7'h61, 7'h63, 7'h65, 7'h57, 7'h61, 7'h72, 7'h65
    };

    typedef logic [BYTE_W-1:0] t_byte7;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
        logic signed [AXIS_W-1:0] axis_rx;
        logic signed [AXIS_W-1:0] axis_ry;
        logic signed [AXIS_W-1:0] axis_rz;
        logic [BYTE_W-1:0]        buttons;
        logic [BYTE_W-1:0]        error_flags;
    } t_result;

endpackage

`default_nettype wire

[rtl/sapd_decode.sv]
// Combinational decode of a closed packet from the stored bytes.
`default_nettype none

module sapd_decode #(
    parameter int unsigned CNT_W = 7
) (
    input  sapd_pkg::t_byte7  i_bytes [sapd_pkg::STORE_DEPTH],
    input  logic [CNT_W-1:0]  i_count,
    input  sapd_pkg::t_byte7  i_xor,
    output logic              o_valid,
    output sapd_pkg::t_result o_result
);
    import sapd_pkg::*;

    t_byte7      d [STORE_DEPTH];
    logic        base_ok;
    logic        is_len4;
    logic        is_len5;
    logic        is_len12;
    logic        is_motion;
    logic        is_keys;
    logic        is_error;

    always_comb begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            d[k] = i_bytes[k];
        end
        for (int k = 0; k < KEY_LEN; k++) begin
            d[k+2] = i_bytes[k+2] ^ DESCRAMBLE_KEY[k];
        end
    end

    assign base_ok   = (i_count >= CNT_W'(2)) && (i_xor == '0);
    assign is_len4   = (i_count == CNT_W'(LEN_ERROR));
    assign is_len5   = (i_count == CNT_W'(LEN_KEYS));
    assign is_len12  = (i_count == CNT_W'(LEN_MOTION));
    assign is_motion = base_ok && (i_bytes[0] == TYPE_MOTION) && is_len12;
    assign is_keys   = base_ok && (i_bytes[0] == TYPE_KEYS) && is_len5;
    assign is_error  = base_ok && (i_bytes[0] == TYPE_ERROR) && is_len4;
    assign o_valid   = is_motion || is_keys || is_error;

    always_comb begin
        o_result = '0;
        if (is_motion) begin
            o_result.kind    = KIND_MOTION;
            o_result.axis_x  = {d[2], d[3][6:4]};
            o_result.axis_y  = {d[3][3:0], d[4][6:1]};
            // the 'E'-style overlap: bit 0 of byte 4 tops it, bits 6:5 fill the bottom
            o_result.axis_z  = {d[4][0], d[5], d[4][6:5]};
            o_result.axis_rx = {d[6][4:0], d[7][6:2]};
            o_result.axis_ry = {d[7][1:0], d[8][6:0], d[7][6]};
            o_result.axis_rz = {d[9][5:0], d[10][6:3]};
            o_result.buttons = i_bytes[1];
        end else if (is_keys) begin
            o_result.kind    = KIND_KEYS;
            o_result.buttons = i_bytes[2];
        end else if (is_error) begin
            o_result.kind        = KIND_ERROR;
            o_result.error_flags = i_bytes[1];
        end
    end

endmodule

`default_nettype wire

[rtl/six_axis_serial_packet_decoder.sv]
// Top level: byte collection, packet close and registered result stream.
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata[7:0] rx_byte
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tuser kind, tdata axes/buttons/errors
//
// One byte per cycle while s_axis is ready. A start byte closes the open packet and
// a valid result is registered at the same edge; it appears on m_axis the cycle after.
// Synchronous active-low reset clears the count, running XOR and result valid.
// s_axis is held off only while a result waits and m_axis is stalled.
`default_nettype none

module six_axis_serial_packet_decoder #(
    parameter int unsigned BUFFER_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [9:0] axis_x, [19:10] axis_y, [29:20] axis_z,
                                          // [39:30] axis_rx, [49:40] axis_ry,
                                          // [59:50] axis_rz, [66:60] buttons,
                                          // [73:67] error_flags, [79:74] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] kind
);
    import sapd_pkg::*;

    localparam int unsigned CNT_W = $clog2(BUFFER_LIMIT + 1);

    t_byte7            r_bytes [STORE_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    t_byte7            r_xor;
    t_byte7            n_xor;
    logic              r_valid;
    t_result           r_result;

    logic              s_accept;
    logic              start;
    logic [CNT_W-1:0]  base_count;
    t_byte7            base_xor;
    t_byte7            val;
    logic              room;
    logic              store_en;
    logic              close_valid;
    t_result           close_result;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign start           = !i_s_axis_tdata[7];
    assign val             = i_s_axis_tdata[6:0];

    // a start byte restarts the packet before it is stored
    assign base_count = start ? '0 : r_count;
    assign base_xor   = start ? '0 : r_xor;
    assign room       = base_count < CNT_W'(BUFFER_LIMIT);
    assign store_en   = s_accept && room && (base_count < CNT_W'(STORE_DEPTH));
    assign n_count    = room ? base_count + CNT_W'(1) : base_count;
    assign n_xor      = room ? base_xor ^ val : base_xor;

    sapd_decode #(
        .CNT_W (CNT_W)
    ) u_decode (
        .i_bytes  (r_bytes),
        .i_count  (r_count),
        .i_xor    (r_xor),
        .o_valid  (close_valid),
        .o_result (close_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_xor   <= '0;
        end else if (s_accept) begin
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_bytes[base_count[STORE_IDX_W-1:0]] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_accept && start && close_valid) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && start && close_valid) begin
            r_result <= close_result;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_result.kind;
    assign o_m_axis_tdata  = {6'b0, r_result.error_flags, r_result.buttons,
                              r_result.axis_rz, r_result.axis_ry, r_result.axis_rx,
                              r_result.axis_z, r_result.axis_y, r_result.axis_x};

endmodule

`default_nettype wire
